// ===== rtl/fgn3d_pkg.sv =====
package fgn3d_pkg;

  localparam int unsigned HashBits   = 8;
  localparam int unsigned FreqBits   = 24;
  localparam int unsigned AmpBits    = 17;
  localparam int unsigned ValBits    = 20;
  localparam int unsigned SumBits    = 24;
  localparam int unsigned RangeBits  = 21;
  localparam int unsigned MaxOctaves = 15;
  localparam logic [FreqBits-1:0] FreqMax = 24'hFFFFFF;
  localparam logic [AmpBits-1:0]  OneQ16  = 17'd65536;

  localparam logic [1:0] REG_BASE_FREQ = 2'd0;
  localparam logic [1:0] REG_OCTAVES   = 2'd1;
  localparam logic [1:0] REG_LACUN     = 2'd2;
  localparam logic [1:0] REG_PERSIST   = 2'd3;

  typedef struct packed {
    logic signed [31:0]  px;
    logic signed [31:0]  py;
    logic signed [31:0]  pz;
    logic [FreqBits-1:0] freq;
    logic [AmpBits-1:0]  amp;
    logic                last;
  } octave_job_t;

  localparam logic [7:0] PERM [256] = '{
    8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,
    8'd201,8'd95,8'd96,8'd53,8'd194,8'd233,8'd7,8'd225,
    8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
    8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,
    8'd247,8'd120,8'd234,8'd75,8'd0,8'd26,8'd197,8'd62,
    8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
    8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,
    8'd174,8'd20,8'd125,8'd136,8'd171,8'd168,8'd68,8'd175,
    8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
    8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,
    8'd60,8'd211,8'd133,8'd230,8'd220,8'd105,8'd92,8'd41,
    8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
    8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,
    8'd209,8'd76,8'd132,8'd187,8'd208,8'd89,8'd18,8'd169,
    8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
    8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,
    8'd52,8'd217,8'd226,8'd250,8'd124,8'd123,8'd5,8'd202,
    8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
    8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,
    8'd182,8'd189,8'd28,8'd42,8'd223,8'd183,8'd170,8'd213,
    8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
    8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,
    8'd129,8'd22,8'd39,8'd253,8'd19,8'd98,8'd108,8'd110,
    8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
    8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,
    8'd238,8'd210,8'd144,8'd12,8'd191,8'd179,8'd162,8'd241,
    8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
    8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,
    8'd184,8'd84,8'd204,8'd176,8'd115,8'd121,8'd50,8'd45,
    8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
    8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,
    8'd128,8'd195,8'd78,8'd66,8'd215,8'd61,8'd156,8'd180
  };

  function automatic logic signed [ValBits-1:0] grad_dot(
      input logic [3:0] h, input logic signed [ValBits-1:0] x,
      input logic signed [ValBits-1:0] y, input logic signed [ValBits-1:0] z);
    logic signed [ValBits-1:0] r;
    case (h)
      4'd0, 4'd12: r = x + y;
      4'd1, 4'd13: r = y - x;
      4'd2:        r = x - y;
      4'd3:        r = -x - y;
      4'd4:        r = x + z;
      4'd5:        r = z - x;
      4'd6:        r = x - z;
      4'd7:        r = -x - z;
      4'd8:        r = y + z;
      4'd9, 4'd14: r = z - y;
      4'd10:       r = y - z;
      default:     r = -y - z;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/fgn3d_queue.sv =====
module fgn3d_queue import fgn3d_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  octave_job_t push_data_i,
  output logic        full_o,
  input  logic        pop_i,
  output octave_job_t pop_data_o,
  output logic        empty_o
);

  octave_job_t mem_q [2];
  logic        wr_q, rd_q;
  logic [1:0]  cnt_q;

  assign full_o     = (cnt_q == 2'd2);
  assign empty_o    = (cnt_q == 2'd0);
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i && !full_o) wr_q <= ~wr_q;
      if (pop_i && !empty_o) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'((push_i && !full_o) ? 1 : 0) - 2'((pop_i && !empty_o) ? 1 : 0);
    end
  end

endmodule

// ===== rtl/fgn3d_front.sv =====
module fgn3d_front import fgn3d_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [23:0]        cfg_wdata_i,
  input  logic               accept_i,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic signed [31:0] point_z_i,
  output logic               push_o,
  output octave_job_t        job_o,
  input  logic               full_i
);

  logic [FreqBits-1:0] base_q;
  logic [3:0]          oct_q;
  logic [15:0]         lac_q, per_q;
  logic                active_q;
  logic [3:0]          left_q;
  logic [FreqBits-1:0] freq_q;
  logic [AmpBits-1:0]  amp_q;
  logic signed [31:0]  px_q, py_q, pz_q;
  logic [39:0]         fprod;
  logic [32:0]         aprod;
  logic [3:0]          extra;

  assign fprod = freq_q * lac_q;
  assign aprod = amp_q * per_q;
  assign extra = (oct_q > 4'(MaxOctaves)) ? 4'(MaxOctaves) : oct_q;

  assign push_o = active_q && !full_i;
  assign job_o  = '{px: px_q, py: py_q, pz: pz_q, freq: freq_q, amp: amp_q,
                    last: (left_q == 4'd0)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= 24'd65536;
      oct_q  <= 4'd3;
      lac_q  <= 16'd8192;
      per_q  <= 16'd32768;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BASE_FREQ: base_q <= cfg_wdata_i;
        REG_OCTAVES:   oct_q  <= cfg_wdata_i[3:0];
        REG_LACUN:     lac_q  <= cfg_wdata_i[15:0];
        REG_PERSIST:   per_q  <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      left_q   <= 4'd0;
    end else if (accept_i) begin
      active_q <= 1'b1;
      left_q   <= extra;
    end else if (push_o) begin
      if (left_q == 4'd0) begin
        active_q <= 1'b0;
      end else begin
        left_q <= left_q - 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      px_q   <= point_x_i;
      py_q   <= point_y_i;
      pz_q   <= point_z_i;
      freq_q <= base_q;
      amp_q  <= OneQ16;
    end else if (push_o) begin
      freq_q <= (fprod[39:12] > 28'(FreqMax)) ? FreqMax : fprod[35:12];
      amp_q  <= aprod[32:16];
    end
  end

endmodule

// ===== rtl/fgn3d_back.sv =====
module fgn3d_back import fgn3d_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  octave_job_t        job_i,
  output logic               pop_o,
  output logic               result_valid_o,
  output logic signed [15:0] noise_value_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SPLIT = 4'd1;
  localparam logic [3:0] S_ST1   = 4'd2;
  localparam logic [3:0] S_ST2   = 4'd3;
  localparam logic [3:0] S_ST3   = 4'd4;
  localparam logic [3:0] S_LX    = 4'd5;
  localparam logic [3:0] S_LY    = 4'd6;
  localparam logic [3:0] S_LZ    = 4'd7;
  localparam logic [3:0] S_WT    = 4'd8;
  localparam logic [3:0] S_DIV   = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;
  localparam int unsigned NumBits = 38;

  function automatic logic signed [ValBits-1:0] lerp(
      input logic signed [ValBits-1:0] a, input logic signed [ValBits-1:0] b,
      input logic [AmpBits-1:0] s);
    logic signed [ValBits:0]   diff;
    logic signed [ValBits+AmpBits:0] p;
    diff = {b[ValBits-1], b} - {a[ValBits-1], a};
    p    = diff * $signed({1'b0, s});
    return a + ValBits'(p >>> 16);
  endfunction

  logic [3:0]  st_q;
  octave_job_t job_q;
  logic [HashBits-1:0] cell_q [3];
  logic [15:0] t_q [3];
  logic [35:0] ct_q [3];
  logic [31:0] tt_q [3];
  logic [31:0] t3_q [3];
  logic [19:0] b_q [3];
  logic [AmpBits-1:0] s_q [3];
  logic [7:0]  h0_q, h1_q, h00_q, h10_q, h01_q, h11_q;
  logic signed [ValBits-1:0] v_q [8];
  logic signed [ValBits-1:0] lx_q [4];
  logic signed [ValBits-1:0] ly_q [2];
  logic signed [ValBits-1:0] n_q;
  logic signed [SumBits-1:0] sum_q;
  logic signed [SumBits-1:0] sum_d;
  logic [RangeBits-1:0] range_q;
  logic [NumBits-1:0]   quo_q;
  logic [RangeBits:0]   rem_q;
  logic [5:0]           cnt_q;
  logic                 neg_q;
  logic                 valid_q;
  logic signed [15:0]   res_q;

  logic signed [31:0] pt [3];
  logic signed [56:0] sp [3];
  logic signed [ValBits-1:0] o0 [3];
  logic signed [ValBits-1:0] o1 [3];
  logic [35:0] st3 [3];
  logic signed [ValBits+AmpBits:0] wp;
  logic [RangeBits+1:0] rtry;
  logic [SumBits-1:0]   mag;

  assign pt[0] = job_q.px;
  assign pt[1] = job_q.py;
  assign pt[2] = job_q.pz;
  assign pop_o = (st_q == S_IDLE) && !empty_i;
  assign result_valid_o = valid_q;
  assign noise_value_o  = res_q;
  assign wp    = n_q * $signed({1'b0, job_q.amp});
  assign sum_d = sum_q + SumBits'(wp >>> 16);
  assign rtry  = {rem_q, quo_q[NumBits-1]} - {2'b00, range_q};
  assign mag   = sum_d[SumBits-1] ? SumBits'(-sum_d) : SumBits'(sum_d);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sp[k]  = pt[k] * $signed({1'b0, job_q.freq});
      o0[k]  = ValBits'({1'b0, t_q[k]});
      o1[k]  = ValBits'({1'b0, t_q[k]}) - ValBits'(OneQ16);
      st3[k] = t3_q[k][31:16] * b_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= S_IDLE;
      valid_q <= 1'b0;
      cnt_q   <= 6'd0;
    end else begin
      valid_q <= 1'b0;
      case (st_q)
        S_IDLE:  if (!empty_i) st_q <= S_SPLIT;
        S_SPLIT: st_q <= S_ST1;
        S_ST1:   st_q <= S_ST2;
        S_ST2:   st_q <= S_ST3;
        S_ST3:   st_q <= S_LX;
        S_LX:    st_q <= S_LY;
        S_LY:    st_q <= S_LZ;
        S_LZ:    st_q <= S_WT;
        S_WT: begin
          if (job_q.last) begin
            st_q  <= S_DIV;
            cnt_q <= 6'(NumBits - 1);
          end else begin
            st_q <= S_IDLE;
          end
        end
        S_DIV: begin
          if (cnt_q == 6'd0) st_q <= S_OUT;
          else cnt_q <= cnt_q - 6'd1;
        end
        S_OUT: begin
          valid_q <= 1'b1;
          st_q    <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      S_IDLE: if (!empty_i) job_q <= job_i;
      S_SPLIT: begin
        for (int k = 0; k < 3; k++) begin
          cell_q[k] <= sp[k][32 +: HashBits];
          t_q[k]    <= sp[k][31:16];
        end
      end
      S_ST1: begin
        h0_q <= PERM[cell_q[0]];
        h1_q <= PERM[cell_q[0] + 8'd1];
        for (int k = 0; k < 3; k++) begin
          ct_q[k] <= (20'd983040 - 20'(6 * t_q[k])) * t_q[k];
          tt_q[k] <= t_q[k] * t_q[k];
        end
      end
      S_ST2: begin
        h00_q <= PERM[h0_q + cell_q[1]];
        h10_q <= PERM[h1_q + cell_q[1]];
        h01_q <= PERM[h0_q + cell_q[1] + 8'd1];
        h11_q <= PERM[h1_q + cell_q[1] + 8'd1];
        for (int k = 0; k < 3; k++) begin
          t3_q[k] <= tt_q[k][31:16] * t_q[k];
          b_q[k]  <= 20'd655360 - ct_q[k][35:16];
        end
      end
      S_ST3: begin
        v_q[0] <= grad_dot(PERM[h00_q + cell_q[2]][3:0], o0[0], o0[1], o0[2]);
        v_q[1] <= grad_dot(PERM[h10_q + cell_q[2]][3:0], o1[0], o0[1], o0[2]);
        v_q[2] <= grad_dot(PERM[h01_q + cell_q[2]][3:0], o0[0], o1[1], o0[2]);
        v_q[3] <= grad_dot(PERM[h11_q + cell_q[2]][3:0], o1[0], o1[1], o0[2]);
        v_q[4] <= grad_dot(PERM[h00_q + cell_q[2] + 8'd1][3:0], o0[0], o0[1], o1[2]);
        v_q[5] <= grad_dot(PERM[h10_q + cell_q[2] + 8'd1][3:0], o1[0], o0[1], o1[2]);
        v_q[6] <= grad_dot(PERM[h01_q + cell_q[2] + 8'd1][3:0], o0[0], o1[1], o1[2]);
        v_q[7] <= grad_dot(PERM[h11_q + cell_q[2] + 8'd1][3:0], o1[0], o1[1], o1[2]);
        for (int k = 0; k < 3; k++) begin
          s_q[k] <= (st3[k][35:16] > 20'(OneQ16)) ? OneQ16 : st3[k][32:16];
        end
      end
      S_LX: begin
        for (int k = 0; k < 4; k++) begin
          lx_q[k] <= lerp(v_q[2*k], v_q[2*k+1], s_q[0]);
        end
      end
      S_LY: begin
        ly_q[0] <= lerp(lx_q[0], lx_q[1], s_q[1]);
        ly_q[1] <= lerp(lx_q[2], lx_q[3], s_q[1]);
      end
      S_LZ: n_q <= lerp(ly_q[0], ly_q[1], s_q[2]);
      S_WT: begin
        sum_q   <= sum_d;
        range_q <= range_q + RangeBits'(job_q.amp);
        if (job_q.last) begin
          rem_q <= '0;
          quo_q <= {mag, 14'd0};
          neg_q <= sum_d[SumBits-1];
        end
      end
      S_DIV: begin
        if (!rtry[RangeBits+1]) begin
          rem_q <= rtry[RangeBits:0];
          quo_q <= {quo_q[NumBits-2:0], 1'b1};
        end else begin
          rem_q <= {rem_q[RangeBits-1:0], quo_q[NumBits-1]};
          quo_q <= {quo_q[NumBits-2:0], 1'b0};
        end
      end
      S_OUT: begin
        if (!neg_q) begin
          res_q <= (quo_q > 38'd32767) ? 16'sd32767 : 16'(quo_q);
        end else begin
          res_q <= (quo_q > 38'd32768) ? -16'sd32768 : 16'(-quo_q);
        end
      end
      default: ;
    endcase
    if (st_q == S_IDLE && !empty_i && job_i.amp == OneQ16) begin
      sum_q   <= '0;
      range_q <= '0;
    end
  end

endmodule

// ===== rtl/fractal_gradient_noise_3d.sv =====
// Each point passes through the octave loop, once per octave (split, hash and fade, lerps
// in x, y and z, weighting), then through the 38-step divider before the strobe.
// One point is taken at a time: busy stays high until the strobe, so the octave
// loop and the divider hold off the next start.
// Reset clears all control state and restores the register defaults.
// Each result is strobed for one cycle; the receiver cannot stall.
module fractal_gradient_noise_3d import fgn3d_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [23:0]        cfg_wdata_i,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic signed [31:0] point_z_i,
  output logic               result_valid_o,
  output logic signed [15:0] noise_value_o
);

  logic        busy_q, accept, push, pop, full, empty;
  octave_job_t push_job, pop_job;

  assign busy   = busy_q;
  assign accept = start && !busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (accept) begin
      busy_q <= 1'b1;
    end else if (result_valid_o) begin
      busy_q <= 1'b0;
    end
  end

  fgn3d_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .accept_i(accept), .point_x_i, .point_y_i, .point_z_i,
    .push_o(push), .job_o(push_job), .full_i(full)
  );

  fgn3d_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .push_data_i(push_job), .full_o(full),
    .pop_i(pop), .pop_data_o(pop_job), .empty_o(empty)
  );

  fgn3d_back u_back (
    .clk_i, .rst_ni, .empty_i(empty), .job_i(pop_job), .pop_o(pop),
    .result_valid_o, .noise_value_o
  );

endmodule
